>>> hdl/pstp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstp_pkg
// Shared types and constants for the pivot-swap to permutation converter.
// ----------------------------------------------------------------------------
package pstp_pkg;

  localparam int MAX_PERM = 64;
  localparam int IDX_W    = $clog2(MAX_PERM);
  localparam int SIZE_W   = 7;
  localparam int ENTRY_W  = 6;
  localparam int PIVOT_W  = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_PERM);

  typedef struct packed {
    logic signed [PIVOT_W-1:0] pivot_row;
    logic                      last_pivot;
  } pstp_in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] perm_entry;
    logic               last_entry;
  } pstp_out_t;

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr_a;
    logic [IDX_W-1:0]   rd_addr_b;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               clear;
  } pstp_tbl_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WR_POS,
    ST_WR_PIV,
    ST_ADVANCE,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } pstp_state_t;

  function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_W'(MAX_PERM)) begin
      r = SIZE_W'(MAX_PERM);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/pstp_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstp_table
// Permutation table: one write port, two registered read ports. Per-entry
// valid bits make an unwritten entry read as its own index (identity).
// ----------------------------------------------------------------------------
module pstp_table
  import pstp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pstp_tbl_cmd_t      cmd,
  output logic      [ENTRY_W-1:0] rd_data_a,
  output logic      [ENTRY_W-1:0] rd_data_b
);

  logic [ENTRY_W-1:0]  mem [MAX_PERM];
  logic [MAX_PERM-1:0] vld;
  logic [ENTRY_W-1:0]  data_a;
  logic [ENTRY_W-1:0]  data_b;
  logic                vld_a;
  logic                vld_b;
  logic [IDX_W-1:0]    addr_a;
  logic [IDX_W-1:0]    addr_b;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      data_a <= mem[cmd.rd_addr_a];
      data_b <= mem[cmd.rd_addr_b];
      addr_a <= cmd.rd_addr_a;
      addr_b <= cmd.rd_addr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else begin
      if (cmd.clear) begin
        vld <= '0;
      end else if (cmd.wr_en) begin
        vld[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        vld_a <= vld[cmd.rd_addr_a];
        vld_b <= vld[cmd.rd_addr_b];
      end
    end
  end

  assign rd_data_a = vld_a ? data_a : ENTRY_W'(addr_a);
  assign rd_data_b = vld_b ? data_b : ENTRY_W'(addr_b);

endmodule
`default_nettype wire

>>> hdl/pstp_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstp_seq
// Sequencer: applies each in-range pivot swap through the table, advances the
// position, and reads the table out entry by entry after the last pivot.
// ----------------------------------------------------------------------------
module pstp_seq
  import pstp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [SIZE_W-1:0]  size,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pstp_in_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pstp_out_t               out_data,
  output pstp_tbl_cmd_t           cmd,
  input  wire logic [ENTRY_W-1:0] rd_data_a,
  input  wire logic [ENTRY_W-1:0] rd_data_b
);

  pstp_state_t       state;
  pstp_state_t       state_next;
  logic [SIZE_W-1:0] position;
  logic [SIZE_W-1:0] size_q;
  logic [IDX_W-1:0]  piv_idx;
  logic [IDX_W-1:0]  emit_idx;
  logic              last_q;
  logic              swap_ok;
  logic              emit_last;

  assign swap_ok = !in_data.pivot_row[PIVOT_W-1]
                   && (PIVOT_W'(unsigned'(in_data.pivot_row)) < PIVOT_W'(size))
                   && (position < size);
  assign emit_last = (SIZE_W'(emit_idx) + SIZE_W'(1)) == size_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      emit_idx <= '0;
      size_q   <= SIZE_RESET;
      last_q   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            size_q <= size;
            last_q <= in_data.last_pivot;
          end
        end
        ST_ADVANCE: begin
          if (position < SIZE_W'(MAX_PERM)) begin
            position <= position + SIZE_W'(1);
          end
          emit_idx <= '0;
        end
        ST_EMIT_OUT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + IDX_W'(1);
            if (emit_last) begin
              position <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      piv_idx <= in_data.pivot_row[IDX_W-1:0];
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    cmd.rd_addr_a = position[IDX_W-1:0];
    cmd.rd_addr_b = piv_idx;
    cmd.wr_addr   = position[IDX_W-1:0];
    cmd.wr_data   = rd_data_b;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = swap_ok ? ST_READ : ST_ADVANCE;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_WR_POS;
      end
      ST_WR_POS: begin
        cmd.wr_en  = 1'b1;
        state_next = ST_WR_PIV;
      end
      ST_WR_PIV: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = piv_idx;
        cmd.wr_data = rd_data_a;
        state_next  = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        state_next = last_q ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = emit_idx;
        state_next    = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (emit_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_data.perm_entry = rd_data_a;
  assign out_data.last_entry = emit_last;

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    position <= SIZE_W'(MAX_PERM))
    else $error("position beyond table depth");

  a_emit_in_size: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (SIZE_W'(emit_idx) < size_q))
    else $error("emit index beyond latched size");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last_entry) |=> (position == '0 && in_ready))
    else $error("table not restarted after final entry");

  a_no_out_after_mid: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_data.last_pivot) |=> !out_valid)
    else $error("result after non-final pivot");

endmodule
`default_nettype wire

>>> hdl/pivot_swaps_to_permutation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pivot_swaps_to_permutation
// Converts LU pivot transpositions into a row permutation.
// ----------------------------------------------------------------------------
// Each pivot transfer swaps the table entry at the current position with the
// entry the pivot names; out-of-range pivots or positions swap nothing. A
// pivot that swaps takes one dual read, then one write per entry through the
// table's single write port, then the position update; a skipped pivot goes
// straight to the position update. After the pivot marked last, the block
// sends perm_size entries, each a registered table read and then the output
// transfer, with any wait on out_ready; then the table is back to identity.
// The input is not ready while a pivot or the readout is in progress.
// The user must write perm_size on the cfg port only while idle; the block
// does not enforce it. 0 counts as 1 and values above 64 as 64.
module pivot_swaps_to_permutation
  import pstp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pstp_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pstp_out_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_data
);

  logic [SIZE_W-1:0]  perm_size;
  logic [SIZE_W-1:0]  size_eff;
  pstp_tbl_cmd_t      cmd;
  logic [ENTRY_W-1:0] rd_data_a;
  logic [ENTRY_W-1:0] rd_data_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_size <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      perm_size <= cfg_data;
    end
  end

  assign size_eff = effective_size(perm_size);

  pstp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .size      (size_eff),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  pstp_table u_table (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

endmodule
`default_nettype wire

>>> tb/pstp_perm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pstp_perm_checker
// Watches the pivot, size and permutation channels of the converter. It keeps
// its own copy of the row table, the position and the size register, predicts
// the permutation emitted at each last pivot, and compares every entry
// transfer in order against that prediction.
// ----------------------------------------------------------------------------
module pstp_perm_checker
  import pstp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire pstp_in_t          in_data,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire pstp_out_t         out_data,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_data,
  output int                     error_count,
  output int                     entries_pending,
  output int                     pivots_seen,
  output int                     entries_seen,
  output int                     perms_seen
);

  logic [ENTRY_W-1:0] row_map [MAX_PERM];
  logic [SIZE_W-1:0]  size_reg;
  logic [SIZE_W-1:0]  step_pos;
  pstp_out_t          expected_entries [$];

  function automatic int clamp_rows(input logic [SIZE_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_PERM) return MAX_PERM;
    return int'(raw);
  endfunction

  task automatic load_identity();
    for (int k = 0; k < MAX_PERM; k++) row_map[k] = ENTRY_W'(k);
    step_pos = '0;
  endtask

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic apply_pivot(input pstp_in_t item);
    int                 rows;
    logic [ENTRY_W-1:0] held;
    pstp_out_t          e;
    rows = clamp_rows(size_reg);
    if (!item.pivot_row[PIVOT_W-1] && item.pivot_row < rows && step_pos < rows) begin
      held = row_map[step_pos[IDX_W-1:0]];
      row_map[step_pos[IDX_W-1:0]] = row_map[item.pivot_row[IDX_W-1:0]];
      row_map[item.pivot_row[IDX_W-1:0]] = held;
    end
    if (step_pos < MAX_PERM) step_pos++;
    if (item.last_pivot) begin
      for (int k = 0; k < rows; k++) begin
        e.perm_entry = row_map[k];
        e.last_entry = (k == rows - 1);
        expected_entries.push_back(e);
      end
      perms_seen++;
      load_identity();
    end
  endtask

  always @(posedge clk) begin
    pstp_out_t e;
    if (rst) begin
      size_reg = SIZE_RESET;
      load_identity();
      expected_entries.delete();
      error_count  = 0;
      pivots_seen  = 0;
      entries_seen = 0;
      perms_seen   = 0;
    end else begin
      if (out_valid && out_ready) begin
        entries_seen++;
        if (expected_entries.size() == 0) begin
          note_error($sformatf("unexpected entry transfer: entry=%0d last=%0b",
                               out_data.perm_entry, out_data.last_entry));
        end else begin
          e = expected_entries.pop_front();
          if (out_data.perm_entry !== e.perm_entry || out_data.last_entry !== e.last_entry)
            note_error($sformatf("entry mismatch: expected entry=%0d last=%0b, got entry=%0d last=%0b",
                                 e.perm_entry, e.last_entry,
                                 out_data.perm_entry, out_data.last_entry));
        end
      end
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
      if (in_valid && in_ready) begin
        pivots_seen++;
        apply_pivot(in_data);
      end
    end
    entries_pending = expected_entries.size();
  end

endmodule

>>> tb/pivot_swaps_to_permutation_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pivot_swaps_to_permutation_test
// Drives pivot sequences and size writes into the converter: a directed set
// for range edges, clamped sizes and a size change inside a matrix, then
// random LU-style pivot sequences with noise under four throttling modes.
// ----------------------------------------------------------------------------
module pivot_swaps_to_permutation_test;
  import pstp_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RANDOM_PIVOTS = 150;
  localparam int DRAIN_CYCLES  = 16;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  pstp_in_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pstp_out_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data = '0;

  int error_count, entries_pending, pivots_seen, entries_seen, perms_seen;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycles         = 0;
  int random_sent    = 0;
  int phases         = 0;

  pivot_swaps_to_permutation u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  pstp_perm_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .entries_pending (entries_pending),
    .pivots_seen     (pivots_seen),
    .entries_seen    (entries_seen),
    .perms_seen      (perms_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_pivot(input logic signed [PIVOT_W-1:0] piv, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.pivot_row  = piv;
    in_data.last_pivot = last;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait for every expected entry, then let any pivot still in flight finish
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (entries_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] raw);
    cfg_valid = 1'b1;
    cfg_data  = raw;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_matrix(input int rows, input int count, input int noise_pct);
    logic signed [PIVOT_W-1:0] piv;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 4))
          0: piv = $urandom;
          1: piv = {1'b1, 31'($urandom)};
          2: piv = rows;
          3: piv = $urandom_range(0, MAX_PERM - 1);
          default: piv = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
      end else if (i < rows) begin
        piv = $urandom_range(i, rows - 1);
      end else begin
        piv = $urandom_range(0, rows - 1);
      end
      send_pivot(piv, i == count - 1);
      random_sent++;
    end
  endtask

  initial begin
    int                rows;
    int                count;
    logic [SIZE_W-1:0] raw;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset size, swap of first and last rows
    send_pivot(63, 1'b1);

    // register zero acts as one row
    quiesce();
    write_size('0);
    send_pivot(0, 1'b1);
    send_pivot(32'sh8000_0000, 1'b0);
    send_pivot(1, 1'b1);

    // register above the table depth saturates
    quiesce();
    write_size(SIZE_W'(127));
    send_pivot(64, 1'b0);
    send_pivot(32'sh7FFF_FFFF, 1'b0);
    send_pivot(63, 1'b1);

    // negative pivot, repeats, position past the size
    quiesce();
    write_size(SIZE_W'(5));
    send_pivot(4, 1'b0);
    send_pivot(3, 1'b0);
    send_pivot(-5, 1'b0);
    send_pivot(4, 1'b0);
    send_pivot(4, 1'b0);
    send_pivot(2, 1'b0);
    send_pivot(0, 1'b1);

    // shrink the size inside a matrix; emitted rows may exceed the new size
    send_pivot(3, 1'b0);
    send_pivot(1, 1'b0);
    quiesce();
    write_size(SIZE_W'(3));
    send_pivot(2, 1'b0);
    send_pivot(0, 1'b1);

    while (random_sent < RANDOM_PIVOTS || phases < 4) begin
      quiesce();
      case (phases % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      case ($urandom_range(0, 9))
        0: rows = 1;
        1: rows = MAX_PERM;
        2, 3: rows = $urandom_range(9, 30);
        default: rows = $urandom_range(2, 8);
      endcase
      raw = SIZE_W'(rows);
      if (rows == 1 && $urandom_range(0, 1)) raw = '0;
      if (rows == MAX_PERM && $urandom_range(0, 1)) raw = SIZE_W'($urandom_range(65, 127));
      write_size(raw);
      repeat ($urandom_range(2, 4)) begin
        case ($urandom_range(0, 9))
          0: count = $urandom_range(1, rows);
          1: count = rows + $urandom_range(1, 4);
          default: count = rows;
        endcase
        send_matrix(rows, count, 12);
      end
      phases++;
    end

    // long matrix: the position must saturate rather than wrap
    quiesce();
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    write_size(SIZE_W'(2));
    send_matrix(2, 131, 0);

    quiesce();
    $display("Run: %0d pivot transfers over %0d random phases, %0d permutations.",
             pivots_seen, phases, perms_seen);
    $display("Checked %0d entry transfers, sizes 1..64 incl. clamped writes, four throttle modes.",
             entries_seen);
    if (error_count == 0 && entries_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Mismatches: %0d", error_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
